>>> rtl/core/rpd_pkg.sv
// Package with the shared types and constants of the packet deframer.
package rpd_pkg;

   // Protocol characters.
   localparam logic [7:0] CH_START = 8'h24;
   localparam logic [7:0] CH_END   = 8'h23;
   localparam logic [7:0] CH_NAK   = 8'h2D;
   localparam logic [7:0] CH_ACK   = 8'h2B;

   // Length limit: MAX_LEN capped to what the position field can hold.
   localparam int POS_W     = 10;
   localparam int MAX_LEN   = 1023;
   localparam int POS_CAP   = (1 << POS_W) - 1;
   localparam int LEN_LIMIT = (MAX_LEN > POS_CAP) ? POS_CAP : MAX_LEN;

   // Command queue between the classifier and the executor.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;
   localparam logic [1:0] KIND_RESEND  = 2'd3;

   // Receive phases.
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DATA = 2'd1,
      PH_DIG1 = 2'd2,
      PH_DIG2 = 2'd3
   } phase_type;

   // One classified input byte.
   typedef struct packed {
      logic [7:0] data;
      logic       is_start;
      logic       is_end;
      logic       is_nak;
      logic [3:0] nibble;
      logic       hex_bad;
   } cmd_type;

endpackage

>>> rtl/core/rpd_front.sv
// Front end: classifies each received byte and decodes it as a hex digit.
module rpd_front (
   input  logic            [7:0] rx_byte,
   output rpd_pkg::cmd_type      cmd
);

   logic [3:0] nibble;
   logic       hex_bad;

   // Hex digit decode, either case; anything else is flagged as bad.
   always_comb begin
      nibble  = 4'd0;
      hex_bad = 1'b0;
      if (rx_byte inside {[8'h30:8'h39]}) begin
         nibble = 4'(rx_byte - 8'h30);
      end else if (rx_byte inside {[8'h61:8'h66]}) begin
         nibble = 4'(rx_byte - 8'h57);
      end else if (rx_byte inside {[8'h41:8'h46]}) begin
         nibble = 4'(rx_byte - 8'h37);
      end else begin
         hex_bad = 1'b1;
      end
   end

   // Marker classification.
   always_comb begin
      cmd.data     = rx_byte;
      cmd.is_start = (rx_byte == rpd_pkg::CH_START);
      cmd.is_end   = (rx_byte == rpd_pkg::CH_END);
      cmd.is_nak   = (rx_byte == rpd_pkg::CH_NAK);
      cmd.nibble   = nibble;
      cmd.hex_bad  = hex_bad;
   end

endmodule

>>> rtl/core/rpd_cmd_queue.sv
// Short queue of classified requests between the front end and the executor.
module rpd_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rpd_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop,
   output rpd_pkg::cmd_type pop_cmd
);

   rpd_pkg::cmd_type                    entry_ff [rpd_pkg::QUEUE_DEPTH];
   logic [rpd_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [rpd_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [rpd_pkg::QCNT_W-1:0]          count_ff, count_in;
   logic                                do_push;
   logic                                do_pop;

   assign push_ready = (count_ff != rpd_pkg::QCNT_W'(rpd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == rpd_pkg::QPTR_W'(rpd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rpd_pkg::QPTR_W'(rpd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/rpd_back.sv
// Back end: runs the packet state machine and holds the result register.
module rpd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ack_enabled,
   input  logic                          cmd_valid,
   input  rpd_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_kind,
   output logic [7:0]                    rsp_payload_byte,
   output logic [rpd_pkg::POS_W-1:0]     rsp_position,
   output logic [7:0]                    rsp_sum_computed,
   output logic [7:0]                    rsp_sum_received,
   output logic                          rsp_reply_valid,
   output logic [7:0]                    rsp_reply_byte
);

   rpd_pkg::phase_type             phase_ff, phase_in;
   logic [7:0]                     sum_ff, sum_in;
   logic [3:0]                     high_nibble_ff, high_nibble_in;
   logic                           high_bad_ff, high_bad_in;
   logic [rpd_pkg::POS_W-1:0]      count_ff, count_in;

   logic                           out_valid_ff, out_valid_in;
   logic [1:0]                     kind_ff, kind_in;
   logic [7:0]                     pbyte_ff, pbyte_in;
   logic [rpd_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [7:0]                     sc_ff, sc_in;
   logic [7:0]                     sr_ff, sr_in;
   logic                           rv_ff, rv_in;
   logic [7:0]                     rb_ff, rb_in;

   logic                           emit;
   logic [7:0]                     recv;
   logic                           good;

   // A request is taken whenever the result register is free or drains now.
   assign cmd_pop = cmd_valid && (!out_valid_ff || rsp_ready);

   assign recv = {high_nibble_ff, cmd.nibble};
   assign good = !cmd.hex_bad && !high_bad_ff && (recv == sum_ff);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (cmd_pop) begin
         case (phase_ff)
            rpd_pkg::PH_IDLE: begin
               if (cmd.is_start) phase_in = rpd_pkg::PH_DATA;
            end
            rpd_pkg::PH_DATA: begin
               if (cmd.is_end) phase_in = rpd_pkg::PH_DIG1;
            end
            rpd_pkg::PH_DIG1: phase_in = rpd_pkg::PH_DIG2;
            rpd_pkg::PH_DIG2: phase_in = rpd_pkg::PH_IDLE;
            default:          phase_in = rpd_pkg::PH_IDLE;
         endcase
      end
   end

   // Datapath updates and the result for the request being taken.
   always_comb begin
      sum_in         = sum_ff;
      high_nibble_in = high_nibble_ff;
      high_bad_in    = high_bad_ff;
      count_in       = count_ff;
      emit           = 1'b0;
      kind_in        = rpd_pkg::KIND_PAYLOAD;
      pbyte_in       = 8'd0;
      pos_in         = '0;
      sc_in          = 8'd0;
      sr_in          = 8'd0;
      rv_in          = 1'b0;
      rb_in          = 8'd0;
      if (cmd_pop) begin
         case (phase_ff)
            rpd_pkg::PH_IDLE: begin
               if (cmd.is_start) begin
                  sum_in         = 8'd0;
                  count_in       = '0;
                  high_nibble_in = 4'd0;
                  high_bad_in    = 1'b0;
               end else if (cmd.is_nak) begin
                  emit    = 1'b1;
                  kind_in = rpd_pkg::KIND_RESEND;
               end
            end
            rpd_pkg::PH_DATA: begin
               if (!cmd.is_end) begin
                  emit     = 1'b1;
                  kind_in  = rpd_pkg::KIND_PAYLOAD;
                  pbyte_in = cmd.data;
                  pos_in   = count_ff;
                  sum_in   = sum_ff + cmd.data;
                  if (count_ff < rpd_pkg::POS_W'(rpd_pkg::LEN_LIMIT)) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            rpd_pkg::PH_DIG1: begin
               high_nibble_in = cmd.nibble;
               high_bad_in    = cmd.hex_bad;
            end
            rpd_pkg::PH_DIG2: begin
               emit    = 1'b1;
               kind_in = good ? rpd_pkg::KIND_GOOD : rpd_pkg::KIND_BAD;
               pos_in  = count_ff;
               sc_in   = sum_ff;
               sr_in   = recv;
               rv_in   = ack_enabled;
               if (ack_enabled) begin
                  rb_in = good ? rpd_pkg::CH_ACK : rpd_pkg::CH_NAK;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // Result register valid: loads on a new result, clears when taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd_pop && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= rpd_pkg::PH_IDLE;
         sum_ff         <= 8'd0;
         high_nibble_ff <= 4'd0;
         high_bad_ff    <= 1'b0;
         count_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         sum_ff         <= sum_in;
         high_nibble_ff <= high_nibble_in;
         high_bad_ff    <= high_bad_in;
         count_ff       <= count_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (cmd_pop && emit) begin
         kind_ff  <= kind_in;
         pbyte_ff <= pbyte_in;
         pos_ff   <= pos_in;
         sc_ff    <= sc_in;
         sr_ff    <= sr_in;
         rv_ff    <= rv_in;
         rb_ff    <= rb_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = pbyte_ff;
   assign rsp_position     = pos_ff;
   assign rsp_sum_computed = sc_ff;
   assign rsp_sum_received = sr_ff;
   assign rsp_reply_valid  = rv_ff;
   assign rsp_reply_byte   = rb_ff;

endmodule

>>> rtl/core/rsp_packet_deframer.sv
// Top level of the packet deframer.
//
// Requests carry one received byte on req_rx_byte with a valid/ready
// handshake. Bytes outside a packet are dropped, except that '-' gives a
// resend result. Inside a packet each payload byte comes out as a result
// with its position; after '#' and two hex digits a verdict result gives
// good or bad, the length and both sums, plus a reply byte when
// acknowledgements are on (csr_ack_enabled, written when csr_we is high).
// One request is taken per cycle while req_ready is high. The accepting
// edge writes the request into the command queue; from there it moves
// through the state machine into the result register, whose output drives
// rsp_valid, once that register is free or being drained.
// The two-entry command queue and the result register let requests keep
// flowing while a result waits; when the receiver stalls, the result holds
// and the queue fills, then req_ready drops and comes back in the cycle
// after the waiting result is taken.
// Reset clears the queue, the result register and the packet state, and sets
// acknowledgements on.
module rsp_packet_deframer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_payload_byte,
   output logic [rpd_pkg::POS_W-1:0] rsp_position,
   output logic [7:0]                rsp_sum_computed,
   output logic [7:0]                rsp_sum_received,
   output logic                      rsp_reply_valid,
   output logic [7:0]                rsp_reply_byte,
   input  logic                      csr_we,
   input  logic                      csr_ack_enabled
);

   rpd_pkg::cmd_type front_cmd;
   rpd_pkg::cmd_type queue_cmd;
   logic             queue_valid;
   logic             queue_pop;
   logic             ack_enabled_ff, ack_enabled_in;

   // Acknowledgement mode register.
   assign ack_enabled_in = csr_we ? csr_ack_enabled : ack_enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_enabled_ff <= 1'b1;
      end else begin
         ack_enabled_ff <= ack_enabled_in;
      end
   end

   rpd_front u_front (
      .rx_byte (req_rx_byte),
      .cmd     (front_cmd)
   );

   rpd_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_cmd    (queue_cmd)
   );

   rpd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .ack_enabled      (ack_enabled_ff),
      .cmd_valid        (queue_valid),
      .cmd              (queue_cmd),
      .cmd_pop          (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_position     (rsp_position),
      .rsp_sum_computed (rsp_sum_computed),
      .rsp_sum_received (rsp_sum_received),
      .rsp_reply_valid  (rsp_reply_valid),
      .rsp_reply_byte   (rsp_reply_byte)
   );

endmodule

>>> rtl/core/rpd_checker.sv
// Port-level checks for the packet deframer, bound to its top level.
module rpd_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [1:0]                rsp_kind,
   input  logic [7:0]                rsp_payload_byte,
   input  logic [rpd_pkg::POS_W-1:0] rsp_position,
   input  logic [7:0]                rsp_sum_computed,
   input  logic [7:0]                rsp_sum_received,
   input  logic                      rsp_reply_valid,
   input  logic [7:0]                rsp_reply_byte
);

   // No result is shown in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds its payload.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_position)
         && $stable(rsp_reply_byte))
      else $error("stalled result changed");

   // Payload results carry no sums and no reply.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == rpd_pkg::KIND_PAYLOAD |->
         !rsp_reply_valid && rsp_reply_byte == 8'd0
         && rsp_sum_computed == 8'd0 && rsp_sum_received == 8'd0)
      else $error("payload result with verdict fields");

   // A reply byte matches the verdict.
   a_reply_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_valid |->
         (rsp_kind == rpd_pkg::KIND_GOOD && rsp_reply_byte == rpd_pkg::CH_ACK)
         || (rsp_kind == rpd_pkg::KIND_BAD && rsp_reply_byte == rpd_pkg::CH_NAK))
      else $error("reply byte does not match verdict");

   // A good verdict means the two sums agree.
   a_good_sums: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == rpd_pkg::KIND_GOOD |->
         rsp_sum_computed == rsp_sum_received)
      else $error("good verdict with differing sums");

endmodule

bind rsp_packet_deframer rpd_checker u_rpd_checker (.*);

>>> tb/rsp_packet_deframer_tb.sv
// Self-checking testbench for the packet deframer with a byte-level predictor and scoreboard.
`timescale 1ns / 100ps

module rsp_packet_deframer_tb;

   // Hex digit characters used to build checksum fields.
   localparam logic [7:0] DIGIT_0 = 8'h30;
   localparam logic [7:0] DIGIT_9 = 8'h39;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_F = 8'h66;
   localparam logic [7:0] UPPER_A = 8'h41;
   localparam logic [7:0] UPPER_F = 8'h46;

   // Ways a random packet can end.
   localparam int FLAVOR_GOOD      = 0;
   localparam int FLAVOR_WRONG_SUM = 1;
   localparam int FLAVOR_BAD_DIGIT = 2;
   localparam int FLAVOR_CUT       = 3;

   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;

   // One result of the deframer, in the order of the result ports.
   typedef struct packed {
      logic [1:0]                kind;
      logic [7:0]                payload_byte;
      logic [rpd_pkg::POS_W-1:0] position;
      logic [7:0]                sum_computed;
      logic [7:0]                sum_received;
      logic                      reply_valid;
      logic [7:0]                reply_byte;
   } deframe_event_type;

   // Tracks the receive state of the block and the results still owed by it.
   class deframer_scoreboard;
      logic                      ack_on = 1'b1;
      rpd_pkg::phase_type        rx_phase = rpd_pkg::PH_IDLE;
      logic [7:0]                sum_acc = 8'h00;
      logic [3:0]                hi_nibble = 4'h0;
      logic                      hi_bad = 1'b0;
      logic [rpd_pkg::POS_W-1:0] byte_count = '0;
      deframe_event_type         events_due[$];
      int                        errors = 0;

      function int pending();
         return events_due.size();
      endfunction

      // Decodes one hex digit in either case; anything else reads as zero and is flagged.
      function logic [3:0] hex_nibble(input logic [7:0] c, output logic bad);
         bad = 1'b0;
         if (c >= DIGIT_0 && c <= DIGIT_9) return 4'(c - DIGIT_0);
         if (c >= LOWER_A && c <= LOWER_F) return 4'(c - LOWER_A + 10);
         if (c >= UPPER_A && c <= UPPER_F) return 4'(c - UPPER_A + 10);
         bad = 1'b1;
         return 4'h0;
      endfunction

      function string describe(input deframe_event_type e);
         return $sformatf("kind=%0d byte=%02h pos=%0d sum=%02h recv=%02h reply=%b/%02h",
                          e.kind, e.payload_byte, e.position, e.sum_computed,
                          e.sum_received, e.reply_valid, e.reply_byte);
      endfunction

      // Advances the receive state by one accepted request byte.
      function void deframe_byte(input logic [7:0] b);
         deframe_event_type ev;
         logic              bad;
         logic [3:0]        lo;
         logic [7:0]        recv;
         logic              good;
         ev = '0;
         case (rx_phase)
            rpd_pkg::PH_IDLE: begin
               if (b == rpd_pkg::CH_START) begin
                  rx_phase = rpd_pkg::PH_DATA;
                  sum_acc = 8'h00;
                  byte_count = '0;
                  hi_nibble = 4'h0;
                  hi_bad = 1'b0;
               end else if (b == rpd_pkg::CH_NAK) begin
                  ev.kind = rpd_pkg::KIND_RESEND;
                  events_due.push_back(ev);
               end
            end
            rpd_pkg::PH_DATA: begin
               if (b == rpd_pkg::CH_END) begin
                  rx_phase = rpd_pkg::PH_DIG1;
               end else begin
                  ev.kind = rpd_pkg::KIND_PAYLOAD;
                  ev.payload_byte = b;
                  ev.position = byte_count;
                  events_due.push_back(ev);
                  sum_acc = sum_acc + b;
                  if (byte_count < rpd_pkg::LEN_LIMIT) byte_count = byte_count + 1'b1;
               end
            end
            rpd_pkg::PH_DIG1: begin
               hi_nibble = hex_nibble(b, bad);
               hi_bad = bad;
               rx_phase = rpd_pkg::PH_DIG2;
            end
            default: begin
               lo = hex_nibble(b, bad);
               recv = {hi_nibble, lo};
               good = !bad && !hi_bad && (recv == sum_acc);
               ev.kind = good ? rpd_pkg::KIND_GOOD : rpd_pkg::KIND_BAD;
               ev.position = byte_count;
               ev.sum_computed = sum_acc;
               ev.sum_received = recv;
               ev.reply_valid = ack_on;
               ev.reply_byte = ack_on ? (good ? rpd_pkg::CH_ACK : rpd_pkg::CH_NAK) : 8'h00;
               events_due.push_back(ev);
               rx_phase = rpd_pkg::PH_IDLE;
            end
         endcase
      endfunction

      // Compares one accepted result against the oldest one owed.
      function void check_event(input deframe_event_type got);
         deframe_event_type want;
         if (events_due.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none, actual %s", $time, describe(got));
            return;
         end
         want = events_due.pop_front();
         if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
             got.position !== want.position || got.sum_computed !== want.sum_computed ||
             got.sum_received !== want.sum_received || got.reply_valid !== want.reply_valid ||
             got.reply_byte !== want.reply_byte) begin
            errors++;
            $display("%0t result mismatch: expected %s, actual %s",
                     $time, describe(want), describe(got));
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_rx_byte = 8'h00;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_kind;
   logic [7:0]                rsp_payload_byte;
   logic [rpd_pkg::POS_W-1:0] rsp_position;
   logic [7:0]                rsp_sum_computed;
   logic [7:0]                rsp_sum_received;
   logic                      rsp_reply_valid;
   logic [7:0]                rsp_reply_byte;
   logic                      csr_we = 1'b0;
   logic                      csr_ack_enabled = 1'b1;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int          counted_requests = 0;
   int unsigned cycle_count = 0;

   deframer_scoreboard sb = new();

   rsp_packet_deframer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_position     (rsp_position),
      .rsp_sum_computed (rsp_sum_computed),
      .rsp_sum_received (rsp_sum_received),
      .rsp_reply_valid  (rsp_reply_valid),
      .rsp_reply_byte   (rsp_reply_byte),
      .csr_we           (csr_we),
      .csr_ack_enabled  (csr_ack_enabled)
   );

   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side: check what was taken at this edge, then pick the next ready.
   always @(posedge clock) begin : take_results
      deframe_event_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_kind, rsp_payload_byte, rsp_position, rsp_sum_computed,
                 rsp_sum_received, rsp_reply_valid, rsp_reply_byte};
         sb.check_event(seen);
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Random hex digit for a nibble, letters in either case.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 10) return DIGIT_0 + n;
      return 8'(($urandom_range(1) ? LOWER_A : UPPER_A) + n - 10);
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while ((c >= DIGIT_0 && c <= DIGIT_9) || (c >= LOWER_A && c <= LOWER_F) ||
             (c >= UPPER_A && c <= UPPER_F));
      return c;
   endfunction

   // Presents one request byte, with random idle cycles ahead of it, and waits for it to go in.
   task automatic send_byte(input logic [7:0] b, input logic counts);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.deframe_byte(b);
      if (counts) counted_requests++;
   endtask

   // Stops sending and waits until every owed result is back and the pipeline is quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the acknowledgement mode; only called while the block is drained.
   task automatic write_ack(input logic value);
      csr_we <= 1'b1;
      csr_ack_enabled <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.ack_on = value;
   endtask

   // One framed packet with random payload; the flavor decides how the checksum ends.
   task automatic send_packet(input int len, input int flavor);
      logic [7:0] b;
      logic [7:0] sum;
      logic [7:0] claim;
      logic [7:0] hi_c;
      logic [7:0] lo_c;
      sum = 8'h00;
      send_byte(rpd_pkg::CH_START, 1'b1);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(255));
         // Markers inside a packet are plain payload, so feed them in often.
         if ($urandom_range(15) == 0) b = $urandom_range(1) ? rpd_pkg::CH_START : rpd_pkg::CH_NAK;
         if (b == rpd_pkg::CH_END) b = b ^ 8'h01;
         send_byte(b, 1'b1);
         sum = sum + b;
      end
      send_byte(rpd_pkg::CH_END, 1'b1);
      claim = (flavor == FLAVOR_WRONG_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
      hi_c = hex_char(claim[7:4]);
      lo_c = hex_char(claim[3:0]);
      if (flavor == FLAVOR_BAD_DIGIT) begin
         if ($urandom_range(1)) hi_c = non_hex_byte();
         else lo_c = non_hex_byte();
      end
      send_byte(hi_c, 1'b1);
      // A cut packet leaves its second digit to whatever byte comes next.
      if (flavor != FLAVOR_CUT) send_byte(lo_c, 1'b1);
   endtask

   // Mostly well-formed packets, with resends, line noise, cut packets and drain pauses.
   task automatic run_traffic(input int budget);
      int first;
      int pick;
      int flavor;
      int len;
      first = counted_requests;
      while (counted_requests - first < budget) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
            pick = $urandom_range(99);
            flavor = (pick < 60) ? FLAVOR_GOOD : (pick < 80) ? FLAVOR_WRONG_SUM :
                     (pick < 92) ? FLAVOR_BAD_DIGIT : FLAVOR_CUT;
            send_packet(len, flavor);
         end else if (pick < 82) begin
            send_byte(rpd_pkg::CH_NAK, 1'b1);
         end else if (pick < 98) begin
            send_byte(8'($urandom_range(255)), 1'b0);
         end else begin
            drain_results();
         end
      end
   endtask

   initial begin
      logic [7:0] opening_bytes [27];
      opening_bytes = '{
         // Dropped while idle, then a resend request.
         8'hFF, rpd_pkg::CH_NAK,
         // Markers as payload.
         rpd_pkg::CH_START, 8'h00, 8'hFF, rpd_pkg::CH_START, rpd_pkg::CH_NAK,
         rpd_pkg::CH_END, 8'h35, 8'h30,
         // Mixed-case digits.
         rpd_pkg::CH_START, 8'hAB, rpd_pkg::CH_END, 8'h61, 8'h42,
         // Invalid high digit.
         rpd_pkg::CH_START, rpd_pkg::CH_END, 8'h67, 8'h30,
         // Invalid low digit.
         rpd_pkg::CH_START, rpd_pkg::CH_END, 8'h30, 8'h47,
         // Wrong checksum.
         rpd_pkg::CH_START, rpd_pkg::CH_END, 8'h30, 8'h31
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_ack(1'b1);

      // Directed opening with acknowledgements on.
      foreach (opening_bytes[i]) send_byte(opening_bytes[i], 1'b1);
      drain_results();

      // No idling, acknowledgements off, one packet long enough to saturate the length.
      write_ack(1'b0);
      idle_pct = 0;
      stall_pct = 0;
      send_packet(rpd_pkg::LEN_LIMIT + 1 + $urandom_range(12), FLAVOR_GOOD);
      run_traffic(220);
      drain_results();

      // Sender mostly idle.
      write_ack(1'b1);
      idle_pct = 75;
      stall_pct = 0;
      run_traffic(220);
      drain_results();

      // Receiver mostly stalled.
      write_ack(1'b0);
      idle_pct = 0;
      stall_pct = 75;
      run_traffic(220);
      drain_results();

      // Both sides idling now and then.
      write_ack(1'b1);
      idle_pct = 32;
      stall_pct = 32;
      run_traffic(220);
      drain_results();

      if (sb.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
